// ----- src/granular_particle_stress_top_defines.svh -----
// ----------------------------------------------------------------------------
// Granular particle stress assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GRANULAR_PARTICLE_STRESS_TOP_DEFINES_SVH
`define GRANULAR_PARTICLE_STRESS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, disabled during reset.
`define GPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk, disabled during reset.
`define GPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GPS_ASSERT_IMP(lbl, ante, cons, msg)
`define GPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/gps_pkg.sv -----
// ----------------------------------------------------------------------------
// Granular particle stress package
// Field widths, fixed-point constants, register codes and beat types.
// ----------------------------------------------------------------------------
package gps_pkg;

    localparam int ALPHA_W    = 16;
    localparam int RHO_W      = 24;
    localparam int SPEED_W    = 32;
    localparam int STRESS_W   = 48;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;

    // Cube root of a 64-bit quotient: one result bit per three dividend bits.
    localparam int CBRT_STEPS = 22;
    localparam int CBRT_W     = 22;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [31:0] G0_NUM   = 32'd39322;

    localparam logic [CFG_W-1:0] RESTITUTION_RST = 16'd58982;
    localparam logic [CFG_W-1:0] EPS_FLOOR_RST   = 16'd655;
    localparam logic [CFG_W-1:0] PACKED_RST      = 16'd39322;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RESTITUTION = 2'd0,
        CFG_EPS_FLOOR   = 2'd1,
        CFG_PACKED      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [RHO_W-1:0]   rho;
        logic [SPEED_W-1:0] speed_sq;
    } t_cell;

    typedef struct packed {
        logic [STRESS_W-1:0] stress;
        logic                sat;
    } t_result;

endpackage

// ----- src/granular_particle_stress_top.sv -----
// ----------------------------------------------------------------------------
// Granular particle stress, top level
// Per-cell kinetic-collisional particle stress in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: a cell beat (volume fraction Q0.16, density Q16.8, squared speed
// Q16.16) enters on i_in_valid / o_in_ready. One result beat (stress Q32.16
// plus a saturation flag) leaves on o_out_valid / i_out_ready for every cell,
// in order. The configuration registers (restitution, eps floor, packed
// fraction) are written through i_cfg_wr_en / i_cfg_addr / i_cfg_wdata while
// the pipeline is empty; unknown addresses are ignored.
// Throughput is one cell per cycle while the skid register is empty. A cell
// passes 127 register stages: 64 stages for alpha over the packed fraction,
// 22 cube root stages, 2 stages for the floor term and the first products,
// 32 stages for the radial distribution divide, 4 multiply stages, 2 stages
// for the divide by three, and the output register.
// Reset is synchronous and active low; it empties the pipeline and loads
// the default register values. When the receiver stalls, the finished beat
// lands in a one-entry skid register while the output register holds; the
// whole pipeline then freezes until the skid register drains, so nothing is
// lost or repeated.
// ----------------------------------------------------------------------------
module granular_particle_stress_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [gps_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [gps_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [gps_pkg::ALPHA_W-1:0]      i_volume_fraction,
    input  logic [gps_pkg::RHO_W-1:0]        i_density,
    input  logic [gps_pkg::SPEED_W-1:0]      i_speed_sq,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [gps_pkg::STRESS_W-1:0]     o_stress,
    output logic                             o_saturated
);
    import gps_pkg::*;

    localparam logic [65:0] SAT_LIMIT = 66'd3 << 48;

    // Reciprocal of three, rounded up, scaled by 2^51.
    localparam logic [49:0] RECIP3    = 50'd750599937895083;
    localparam logic [24:0] RECIP3_HI = RECIP3[49:25];
    localparam logic [24:0] RECIP3_LO = RECIP3[24:0];

    // Configuration registers.
    logic [CFG_W-1:0] r_restitution;
    logic [CFG_W-1:0] r_eps_floor;
    logic [CFG_W-1:0] r_packed_fraction;
    logic [CFG_W-1:0] packed_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution     <= RESTITUTION_RST;
            r_eps_floor       <= EPS_FLOOR_RST;
            r_packed_fraction <= PACKED_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_RESTITUTION: r_restitution     <= i_cfg_wdata;
                CFG_EPS_FLOOR:   r_eps_floor       <= i_cfg_wdata;
                CFG_PACKED:      r_packed_fraction <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A zero packed fraction is treated as one LSB.
    assign packed_eff = (r_packed_fraction == '0) ? CFG_W'(1) : r_packed_fraction;

    // The pipeline moves as a whole whenever the skid register is empty.
    logic    en;
    logic    r_skid_valid;
    logic    r_out_valid;
    t_result r_skid;
    t_result r_out;

    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    t_cell in_cell;
    assign in_cell = '{alpha: i_volume_fraction, rho: i_density, speed_sq: i_speed_sq};

    // Stage group 1: alpha * 2^48 / packed.
    logic        d1_valid;
    logic [63:0] d1_quot;
    t_cell       d1_cell;

    gps_div #(.DW(64), .VW(CFG_W), .PW($bits(t_cell))) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_num   ({i_volume_fraction, 48'd0}),
        .i_den   (packed_eff),
        .i_pay   (in_cell),
        .o_valid (d1_valid),
        .o_quot  (d1_quot),
        .o_pay   (d1_cell)
    );

    // Stage group 2: bitwise integer cube root, one root bit per stage.
    // Each stage tries y' = 2y+1 by checking (r >> s) >= 12y^2 + 6y + 1,
    // keeping y^2 alongside so no multiplier is needed.
    logic              r_cb_valid [CBRT_STEPS];
    logic [63:0]       r_cb_rem   [CBRT_STEPS];
    logic [CBRT_W-1:0] r_cb_y     [CBRT_STEPS];
    logic [43:0]       r_cb_ysq   [CBRT_STEPS];
    t_cell             r_cb_cell  [CBRT_STEPS];

    for (genvar gj = 0; gj < CBRT_STEPS; gj++) begin : g_cbrt
        localparam int SH = 63 - 3 * gj;
        logic              stage_valid;
        logic [63:0]       stage_rem;
        logic [CBRT_W-1:0] stage_y;
        logic [43:0]       stage_ysq;
        t_cell             stage_cell;
        logic [47:0]       trial;
        logic              take;

        if (gj == 0) begin : g_first
            assign stage_valid = d1_valid;
            assign stage_rem   = d1_quot;
            assign stage_y     = '0;
            assign stage_ysq   = '0;
            assign stage_cell  = d1_cell;
        end else begin : g_next
            assign stage_valid = r_cb_valid[gj-1];
            assign stage_rem   = r_cb_rem[gj-1];
            assign stage_y     = r_cb_y[gj-1];
            assign stage_ysq   = r_cb_ysq[gj-1];
            assign stage_cell  = r_cb_cell[gj-1];
        end

        assign trial = ({4'd0, stage_ysq} << 3) + ({4'd0, stage_ysq} << 2)
                     + ({26'd0, stage_y} << 2) + ({26'd0, stage_y} << 1) + 48'd1;
        assign take  = ((stage_rem >> SH) >= {16'd0, trial});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cb_valid[gj] <= 1'b0;
            end else if (en) begin
                r_cb_valid[gj] <= stage_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cb_rem[gj]  <= take ? stage_rem - ({16'd0, trial} << SH) : stage_rem;
                r_cb_y[gj]    <= {stage_y[CBRT_W-2:0], take};
                r_cb_ysq[gj]  <= take ? (stage_ysq << 2) + ({22'd0, stage_y} << 2) + 44'd1
                                      : (stage_ysq << 2);
                r_cb_cell[gj] <= stage_cell;
            end
        end
    end

    // Stage M: eps * (1 - alpha) and alpha * rho.
    logic              r_m_valid;
    logic [CBRT_W-1:0] r_m_c;
    logic [32:0]       r_m_epsprod;
    logic [31:0]       r_m_ar;
    logic [15:0]       r_m_alpha;
    logic [31:0]       r_m_speed;
    logic [39:0]       n_m_arfull;
    t_cell             cb_cell;

    assign cb_cell    = r_cb_cell[CBRT_STEPS-1];
    assign n_m_arfull = {24'd0, cb_cell.alpha} * {16'd0, cb_cell.rho};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_cb_valid[CBRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_c       <= r_cb_y[CBRT_STEPS-1];
            r_m_epsprod <= {17'd0, r_eps_floor} * (ONE_Q16 - {1'b0, cb_cell.alpha});
            r_m_ar      <= n_m_arfull[39:8];
            r_m_alpha   <= cb_cell.alpha;
            r_m_speed   <= cb_cell.speed_sq;
        end
    end

    // Stage N: denominator D = max(1 - cbrt, max(eps*(1-alpha), 1)),
    // s = alpha*rho*u2 and k = alpha*(1+e).
    logic        r_n_valid;
    logic [16:0] r_n_d;
    logic [47:0] r_n_s;
    logic [16:0] r_n_k;
    logic [16:0] floor_term;
    logic [16:0] a_term;
    logic        a_wins;
    logic [16:0] n_d;
    logic [63:0] n_sfull;
    logic [32:0] n_kfull;

    assign floor_term = (r_m_epsprod[32:16] == '0) ? 17'd1 : r_m_epsprod[32:16];
    // 1 - cbrt is only a candidate while the root is below one.
    assign a_term  = ONE_Q16 - r_m_c[16:0];
    assign a_wins  = (r_m_c < CBRT_W'(ONE_Q16)) && (a_term > floor_term);
    assign n_d     = a_wins ? a_term : floor_term;
    assign n_sfull = {32'd0, r_m_ar} * {32'd0, r_m_speed};
    assign n_kfull = {17'd0, r_m_alpha} * ({1'b0, r_restitution} + ONE_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (en) begin
            r_n_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_d <= n_d;
            r_n_s <= n_sfull[63:16];
            r_n_k <= n_kfull[32:16];
        end
    end

    // Stage group 3: g0 = 0.6 * 2^16 / D.
    logic        d2_valid;
    logic [31:0] d2_g0;
    logic [64:0] d2_pay;

    gps_div #(.DW(32), .VW(17), .PW(65)) u_div_g0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_n_valid),
        .i_num   (G0_NUM << 16),
        .i_den   (r_n_d),
        .i_pay   ({r_n_s, r_n_k}),
        .o_valid (d2_valid),
        .o_quot  (d2_g0),
        .o_pay   (d2_pay)
    );

    // Stages F1, F2: f = 1 + k*g0.
    logic        r_f1_valid;
    logic [48:0] r_f1_kg;
    logic [47:0] r_f1_s;
    logic        r_f2_valid;
    logic [33:0] r_f2_f;
    logic [47:0] r_f2_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= d2_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_kg <= {32'd0, d2_pay[16:0]} * {17'd0, d2_g0};
            r_f1_s  <= d2_pay[64:17];
            r_f2_f  <= {1'b0, r_f1_kg[48:16]} + {17'd0, ONE_Q16};
            r_f2_s  <= r_f1_s;
        end
    end

    // Stages P1, P2: p = s*f / 2^16 from two partial products, then the
    // overflow check against three times the largest stress.
    logic        r_p1_valid;
    logic [57:0] r_p1_lo;
    logic [57:0] r_p1_hi;
    logic        r_p2_valid;
    logic [49:0] r_p2_p;
    logic        r_p2_sat;
    logic [81:0] p_full;
    logic [65:0] p_val;

    assign p_full = {24'd0, r_p1_lo} + ({24'd0, r_p1_hi} << 24);
    assign p_val  = p_full[81:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid <= r_f2_valid;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_lo  <= {34'd0, r_f2_s[23:0]} * {24'd0, r_f2_f};
            r_p1_hi  <= {34'd0, r_f2_s[47:24]} * {24'd0, r_f2_f};
            r_p2_p   <= p_val[49:0];
            r_p2_sat <= (p_val >= SAT_LIMIT);
        end
    end

    // Stages Q1, Q2: tau = p / 3 as p times the rounded-up reciprocal, then
    // a shift by 51. This is exact for every p below 2^51, which covers all
    // unsaturated products. The operands are split into 25-bit halves so
    // each multiplier stays small; Q2 adds the four partial products.
    logic        r_q1_valid;
    logic        r_q1_sat;
    logic [49:0] r_q1_hh;
    logic [49:0] r_q1_hl;
    logic [49:0] r_q1_lh;
    logic [49:0] r_q1_ll;
    logic        r_q2_valid;
    logic        r_q2_sat;
    logic [47:0] r_q2_quot;
    logic [50:0] q_mid;
    logic [99:0] q_sum;
    t_result     n_res;

    assign q_mid = {1'b0, r_q1_hl} + {1'b0, r_q1_lh};
    assign q_sum = {r_q1_hh, 50'd0} + {24'd0, q_mid, 25'd0} + {50'd0, r_q1_ll};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_valid <= 1'b0;
            r_q2_valid <= 1'b0;
        end else if (en) begin
            r_q1_valid <= r_p2_valid;
            r_q2_valid <= r_q1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_hh   <= {25'd0, r_p2_p[49:25]} * {25'd0, RECIP3_HI};
            r_q1_hl   <= {25'd0, r_p2_p[49:25]} * {25'd0, RECIP3_LO};
            r_q1_lh   <= {25'd0, r_p2_p[24:0]} * {25'd0, RECIP3_HI};
            r_q1_ll   <= {25'd0, r_p2_p[24:0]} * {25'd0, RECIP3_LO};
            r_q1_sat  <= r_p2_sat;
            r_q2_quot <= q_sum[98:51];
            r_q2_sat  <= r_q1_sat;
        end
    end

    assign n_res.stress = r_q2_sat ? '1 : r_q2_quot;
    assign n_res.sat    = r_q2_sat;

    // Output register with a one-entry skid behind it.
    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= r_q2_valid;
            end
        end else if (en && r_q2_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (en && r_q2_valid) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_stress    = r_out.stress;
    assign o_saturated = r_out.sat;

`include "granular_particle_stress_top_defines.svh"

    `GPS_ASSERT_IMP(a_sat_is_max, r_out_valid && r_out.sat, r_out.stress == '1,
        "saturated result without full-scale stress")
    `GPS_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid register holds a beat while the output register is empty")
    `GPS_ASSERT_IMP(a_denominator_nonzero, r_n_valid, r_n_d != '0,
        "radial distribution denominator is zero")

endmodule

// ----- src/gps_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with a side payload riding along.
// ----------------------------------------------------------------------------
module gps_div #(
    parameter int DW = 32,
    parameter int VW = 16,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [DW-1:0] o_quot,
    output logic [PW-1:0] o_pay
);

    logic          r_valid [DW];
    logic [VW-1:0] r_rem   [DW];
    logic [DW-1:0] r_num   [DW];
    logic [VW-1:0] r_den   [DW];
    logic [PW-1:0] r_pay   [DW];

    for (genvar gk = 0; gk < DW; gk++) begin : g_stage
        logic          stage_valid;
        logic [VW-1:0] stage_rem;
        logic [DW-1:0] stage_num;
        logic [VW-1:0] stage_den;
        logic [PW-1:0] stage_pay;
        logic [VW:0]   trial;
        logic          take;
        logic [VW-1:0] n_rem;

        if (gk == 0) begin : g_first
            assign stage_valid = i_valid;
            assign stage_rem   = '0;
            assign stage_num   = i_num;
            assign stage_den   = i_den;
            assign stage_pay   = i_pay;
        end else begin : g_next
            assign stage_valid = r_valid[gk-1];
            assign stage_rem   = r_rem[gk-1];
            assign stage_num   = r_num[gk-1];
            assign stage_den   = r_den[gk-1];
            assign stage_pay   = r_pay[gk-1];
        end

        // The partial remainder stays below the divisor, so the trial fits VW+1 bits.
        assign trial = {stage_rem, stage_num[DW-1]};
        assign take  = (trial >= {1'b0, stage_den});
        assign n_rem = take ? VW'(trial - {1'b0, stage_den}) : trial[VW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[gk] <= 1'b0;
            end else if (i_en) begin
                r_valid[gk] <= stage_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gk] <= n_rem;
                r_num[gk] <= {stage_num[DW-2:0], take};
                r_den[gk] <= stage_den;
                r_pay[gk] <= stage_pay;
            end
        end
    end

    assign o_valid = r_valid[DW-1];
    assign o_quot  = r_num[DW-1];
    assign o_pay   = r_pay[DW-1];

`include "granular_particle_stress_top_defines.svh"

    `GPS_ASSERT_IMP(a_den_nonzero, i_en && i_valid, i_den != '0, "divider fed a zero divisor")
    `GPS_ASSERT_IMP(a_rem_below_den, r_valid[DW-1], r_rem[DW-1] < r_den[DW-1],
        "final remainder not below divisor")
    `GPS_ASSERT_NXT(a_hold_on_stall, !i_en && o_valid, o_valid && $stable(o_quot),
        "divider output moved while stalled")

endmodule
